// ----- rtl/ffbp_pkg.sv -----
// Shared types for the first-fit bin packer: the input and result words
// and the status codes carried in a result. No dependencies.
package ffbp_pkg;

	typedef enum logic [1:0] {
		STATUS_PLACED   = 2'd0,
		STATUS_OVERSIZE = 2'd1,
		STATUS_FULL     = 2'd2
	} ffbp_status_t;

	typedef struct packed {
		logic [15:0] item_size;
		logic        start_set;
	} ffbp_item_t;

	typedef struct packed {
		logic [5:0]   bin_index;
		logic         opened_new;
		logic [6:0]   bins_used;
		ffbp_status_t status;
	} ffbp_result_t;

endpackage

// ----- rtl/first_fit_bin_packer_core.sv -----
// First-fit bin packer core: remainder memory, scan sequencer and result register.
// Depends on ffbp_pkg for the item and result words.
//
// An item is taken when start is high and busy is low. A result word appears on
// result for exactly one cycle with done high, and the receiver must take it
// then. An item larger than the capacity, or the first item of an empty set,
// is answered in the cycle after it is taken. Otherwise the core reads the stored
// remainders of the open bins one per cycle from a memory with separate read and
// write ports, lowest bin first, until one fits or all open bins have been seen;
// busy stays high while the bins are examined. A new item may be started in the
// cycle in which done is high. The capacity register is written through the cfg
// channel, which is always ready; write it only while idle.
module first_fit_bin_packer_core #(
	parameter int MAX_BINS  = 64,
	parameter int SIZE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  ffbp_pkg::ffbp_item_t  item,
	output logic                  done,
	output ffbp_pkg::ffbp_result_t result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [15:0]           cfg_data
);
	import ffbp_pkg::*;

	localparam int IDX_W = $clog2(MAX_BINS);
	localparam int CNT_W = $clog2(MAX_BINS + 1);

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t state_q;

	logic [SIZE_BITS-1:0] mem [MAX_BINS];
	logic [SIZE_BITS-1:0] rd_data_q;
	logic [IDX_W-1:0]     rd_addr;
	logic                 rd_en;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	logic [SIZE_BITS-1:0] wr_data;

	logic [15:0]          cap_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     k_q;
	logic [SIZE_BITS-1:0] size_q;
	logic                 done_q;
	ffbp_result_t         result_q;

	logic                 accept;
	logic [31:0]          cap_ext;
	logic [31:0]          size_ext;
	logic [SIZE_BITS-1:0] cap;
	logic [SIZE_BITS-1:0] size_in;
	logic [CNT_W-1:0]     cnt_start;
	logic                 oversize_in;
	logic                 fit;
	logic                 last;
	logic                 full;
	logic [CNT_W-1:0]     next_k;
	logic [31:0]          k_ext;
	logic [31:0]          cnt_ext;
	logic [31:0]          cnt_inc_ext;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;

	always_comb begin
		accept      = start && !busy;
		cap_ext     = {16'b0, cap_q};
		size_ext    = {16'b0, item.item_size};
		cap         = cap_ext[SIZE_BITS-1:0];
		size_in     = size_ext[SIZE_BITS-1:0];
		cnt_start   = item.start_set ? '0 : cnt_q;
		oversize_in = (size_in > cap);
		fit         = (rd_data_q >= size_q);
		next_k      = k_q + 1'b1;
		last        = (next_k == cnt_q);
		full        = (cnt_q == CNT_W'(MAX_BINS));
		k_ext       = 32'(k_q);
		cnt_ext     = 32'(cnt_q);
		cnt_inc_ext = 32'(cnt_q + 1'b1);

		rd_en   = accept || (state_q == ST_SCAN);
		rd_addr = accept ? '0 : next_k[IDX_W-1:0];

		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = cap - size_q;
		if (accept) begin
			// Empty set: the first fitting item opens bin 0 right away.
			wr_en   = !oversize_in && (cnt_start == '0);
			wr_data = cap - size_in;
		end else if (state_q == ST_SCAN) begin
			if (fit) begin
				wr_en   = 1'b1;
				wr_addr = k_q[IDX_W-1:0];
				wr_data = rd_data_q - size_q;
			end else if (last && !full) begin
				wr_en   = 1'b1;
				wr_addr = cnt_q[IDX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			cap_q   <= 16'hFFFF;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						size_q <= size_in;
						k_q    <= '0;
						cnt_q  <= cnt_start;
						result_q.bin_index  <= '0;
						result_q.opened_new <= 1'b0;
						result_q.bins_used  <= 7'(32'(cnt_start));
						if (oversize_in) begin
							result_q.status <= STATUS_OVERSIZE;
							done_q          <= 1'b1;
						end else if (cnt_start == '0) begin
							result_q.opened_new <= 1'b1;
							result_q.bins_used  <= 7'd1;
							result_q.status     <= STATUS_PLACED;
							cnt_q               <= CNT_W'(1);
							done_q              <= 1'b1;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					k_q <= next_k;
					if (fit) begin
						result_q.bin_index <= k_ext[5:0];
						result_q.status    <= STATUS_PLACED;
						done_q             <= 1'b1;
						state_q            <= ST_IDLE;
					end else if (last) begin
						if (full) begin
							result_q.status <= STATUS_FULL;
						end else begin
							result_q.bin_index  <= cnt_ext[5:0];
							result_q.opened_new <= 1'b1;
							result_q.bins_used  <= cnt_inc_ext[6:0];
							result_q.status     <= STATUS_PLACED;
							cnt_q               <= cnt_q + 1'b1;
						end
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- dv/tb_first_fit_bin_packer_core.sv -----
// Self-checking testbench for first_fit_bin_packer_core: drives item words, predicts
// every placement in a behavioral model of the bins and checks each result word.
// Depends on ffbp_pkg and the core RTL only.
module tb_first_fit_bin_packer_core;
	timeunit 1ns;
	timeprecision 1ps;

	import ffbp_pkg::*;

	localparam int BIN_COUNT    = 64;
	localparam int DRAIN_CYCLES = BIN_COUNT + 8;
	localparam int LIMIT_CYCLES = 1_000_000;

	logic         clk;
	logic         arst_n;
	logic         start;
	logic         busy;
	ffbp_item_t   item;
	logic         done;
	ffbp_result_t result;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [15:0]  cfg_data;

	// Behavioral copy of the bins and the capacity register.
	logic [15:0]  bin_room [BIN_COUNT];
	int           open_count;
	logic [15:0]  capacity;

	ffbp_result_t placements_due [$];
	int           mismatches;
	int           sender_idle_pct;
	int           cycle_count;

	first_fit_bin_packer_core #(
		.MAX_BINS (BIN_COUNT),
		.SIZE_BITS(16)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.done     (done),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("[first_fit_bin_packer_core] ERROR");
			$finish;
		end
	end

	// First-fit placement of one item; updates the bin model and returns the result word.
	function automatic ffbp_result_t place_item(input logic [15:0] size, input logic first);
		ffbp_result_t r;
		bit           hit;
		r = '0;
		r.status = STATUS_PLACED;
		hit = 1'b0;
		if (first)
			open_count = 0;
		if (size > capacity) begin
			r.status = STATUS_OVERSIZE;
		end else begin
			for (int k = 0; k < open_count && !hit; k++) begin
				if (bin_room[k] >= size) begin
					bin_room[k] = bin_room[k] - size;
					r.bin_index = 6'(k);
					hit = 1'b1;
				end
			end
			if (!hit) begin
				if (open_count == BIN_COUNT) begin
					r.status = STATUS_FULL;
				end else begin
					bin_room[open_count] = capacity - size;
					r.bin_index = 6'(open_count);
					r.opened_new = 1'b1;
					open_count++;
				end
			end
		end
		r.bins_used = 7'(open_count);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
		mismatches++;
	endtask

	// Every done cycle carries one result word, compared with the oldest prediction.
	always @(posedge clk) begin
		ffbp_result_t want;
		if (arst_n && done) begin
			if (placements_due.size() == 0) begin
				report_mismatch("unexpected result word, bins_used", result.bins_used, 0);
			end else begin
				want = placements_due.pop_front();
				if (result.bin_index !== want.bin_index)
					report_mismatch("bin_index", result.bin_index, want.bin_index);
				if (result.opened_new !== want.opened_new)
					report_mismatch("opened_new", result.opened_new, want.opened_new);
				if (result.bins_used !== want.bins_used)
					report_mismatch("bins_used", result.bins_used, want.bins_used);
				if (result.status !== want.status)
					report_mismatch("status", result.status, want.status);
			end
		end
	end

	// Sends one item word. With more set and no idle gap, start stays high for the next word.
	task automatic send_item(input logic [15:0] size, input logic first, input bit more);
		ffbp_item_t w;
		int         gap;
		w.item_size = size;
		w.start_set = first;
		start <= 1'b1;
		item <= w;
		do @(posedge clk); while (busy);
		placements_due.insert(placements_due.size(), place_item(size, first));
		gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(8, 1) : 0;
		if (!more && gap == 0)
			gap = 1;
		if (gap != 0)
			start <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	task automatic wait_idle();
		while (placements_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [15:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		capacity = value;
	endtask

	// Zero-size items and the largest sizes under the reset capacity.
	task automatic test_reset_capacity();
		sender_idle_pct = 0;
		send_item(16'hFFFF, 1'b1, 1'b1);
		send_item(16'h0000, 1'b0, 1'b1);
		send_item(16'h0001, 1'b0, 1'b1);
		send_item(16'hFFFF, 1'b0, 1'b1);
		send_item(16'h0000, 1'b1, 1'b1);
		send_item(16'hFFFF, 1'b0, 1'b0);
	endtask

	// The oversize check comes first, even when a bin opened under a larger capacity fits.
	task automatic test_oversize();
		write_capacity(16'd100);
		send_item(16'd101, 1'b1, 1'b1);
		send_item(16'd0, 1'b0, 1'b1);
		send_item(16'd30, 1'b0, 1'b1);
		send_item(16'd100, 1'b0, 1'b0);
		write_capacity(16'd50);
		send_item(16'd60, 1'b0, 1'b1);
		send_item(16'd50, 1'b0, 1'b1);
		send_item(16'hFFFF, 1'b0, 1'b0);
	endtask

	// Fill every bin at a capacity of 1, then offer items with no room left.
	task automatic test_bins_exhausted();
		write_capacity(16'd1);
		for (int i = 0; i < BIN_COUNT; i++)
			send_item(16'd1, i == 0, 1'b1);
		send_item(16'd1, 1'b0, 1'b1);
		send_item(16'd0, 1'b0, 1'b1);
		send_item(16'd2, 1'b0, 1'b1);
		send_item(16'd1, 1'b1, 1'b0);
	endtask

	// Random sets, mostly sorted descending with a start flag on the first word,
	// mixed with unsorted noise that may start a set anywhere.
	task automatic test_random_sets(input logic [15:0] cap, input int idle_pct, input int total);
		int sizes [$];
		int sent;
		int len;
		int kind;
		bit first;
		write_capacity(cap);
		sender_idle_pct = idle_pct;
		sent = 0;
		while (sent < total) begin
			len = $urandom_range(80, 1);
			if (len > total - sent)
				len = total - sent;
			kind = $urandom_range(9);
			sizes.delete();
			for (int i = 0; i < len; i++) begin
				case (kind)
					4, 5, 6: sizes.insert(sizes.size(), $urandom_range(cap, cap / 2));
					7:       sizes.insert(sizes.size(), $urandom_range(cap / 8, 0));
					8:       sizes.insert(sizes.size(), $urandom_range(16'hFFFF, 0));
					9:       sizes.insert(sizes.size(), $urandom_range(cap, 0));
					default: sizes.insert(sizes.size(), $urandom_range(cap, 0));
				endcase
			end
			if (kind < 8)
				sizes.rsort();
			for (int i = 0; i < len; i++) begin
				first = (kind >= 8) ? ($urandom_range(3) == 0) : (i == 0);
				send_item(16'(sizes[i]), first, i != len - 1);
			end
			sent += len;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		sender_idle_pct = 0;
		open_count = 0;
		capacity = 16'hFFFF;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_capacity();
		test_oversize();
		test_bins_exhausted();
		test_random_sets(16'hFFFF, 0, 240);
		test_random_sets(16'd1, 50, 230);
		test_random_sets(16'd12, 10, 240);
		test_random_sets(16'($urandom_range(60000, 1000)), 50, 240);
		test_random_sets(16'hFFFF, 10, 240);

		while (placements_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[first_fit_bin_packer_core] OK");
		else
			$display("[first_fit_bin_packer_core] ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/ffbp_pkg.sv
rtl/first_fit_bin_packer_core.sv
dv/tb_first_fit_bin_packer_core.sv
